[design/dmc_pkg.sv]
// shared constants and types for the direct-mapped cache tag check
package dmc_pkg;

    // address and line geometry
    localparam int ADDR_W     = 32;
    localparam int LINE_COUNT = 16384;
    localparam int IDX_W      = 14;
    localparam int TAG_W      = 32;
    localparam int CNT_W      = 32;

    // register widths and limits
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_W-1:0] OFF_MAX = 4'd8;
    localparam logic [CFG_W-1:0] IDX_MAX = 4'd14;
    localparam logic [CFG_W-1:0] OFF_RESET = 4'd4;
    localparam logic [CFG_W-1:0] IDX_RESET = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 1'd1;

    // tag store entry: valid flag above the tag
    localparam int ENTRY_W = TAG_W + 1;

    // stream widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 80;

    // one classified access on its way from front to back
    typedef struct packed {
        logic [IDX_W-1:0] line_index;
        logic [TAG_W-1:0] tag;
    } dmc_req_t;

endpackage

[design/direct_mapped_cache_tag_check.sv]
// top level of the direct-mapped cache tag check
// Each address on the input stream is split by the offset_bits and index_bits
// registers into a line index and a tag and looked up in a 16384-line tag store;
// one result per address gives the hit flag, the line and saturating access and
// miss counts. A miss marks the line valid and stores the tag. In the back end an
// address passes a registered tag ram read, then compare and write (held while
// the result register is full), and the next address is popped only after that;
// a two-entry queue decouples input acceptance from the lookup. After reset the
// tag store is swept clear one line per cycle, during which s_tready stays low;
// configuration writes are taken at any time but are meant for idle.
module direct_mapped_cache_tag_check import dmc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [31:0] address
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata    // [0] hit, [14:1] line_index,
                                            // [46:15] access_count,
                                            // [78:47] miss_count, [79] zero
);

    logic             clear_busy;
    logic             q_valid;
    dmc_req_t         q_req;
    logic             q_pop;
    logic             hit;
    logic [IDX_W-1:0] line_index;
    logic [CNT_W-1:0] access_count;
    logic [CNT_W-1:0] miss_count;

    dmc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_address  (s_tdata[ADDR_W-1:0]),
        .clear_busy (clear_busy),
        .q_valid    (q_valid),
        .q_req      (q_req),
        .q_pop      (q_pop)
    );

    dmc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_req          (q_req),
        .q_pop          (q_pop),
        .clear_busy     (clear_busy),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_hit          (hit),
        .m_line_index   (line_index),
        .m_access_count (access_count),
        .m_miss_count   (miss_count)
    );

    // pack the result fields, lowest first
    assign m_tdata = {1'b0, miss_count, access_count, line_index, hit};

endmodule

[design/dmc_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/dmc_front.sv]
// front end: geometry registers, address split and request queue
module dmc_front import dmc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ADDR_W-1:0]    s_address,
    input  logic                 clear_busy,
    output logic                 q_valid,
    output dmc_req_t             q_req,
    input  logic                 q_pop
);

    logic [CFG_W-1:0] offset_bits_reg;
    logic [CFG_W-1:0] index_bits_reg;
    logic [CFG_W-1:0] off_eff;
    logic [CFG_W-1:0] ib_eff;
    logic [CFG_W:0]   tag_shift;
    logic [ADDR_W-1:0] shifted;
    logic [IDX_W-1:0] idx_mask;
    dmc_req_t         new_req;

    dmc_req_t q_mem_reg [2];
    logic     wr_ptr_reg;
    logic     rd_ptr_reg;
    logic [1:0] count_reg;
    logic     push;

    // geometry registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= OFF_RESET;
            index_bits_reg  <= IDX_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_wdata;
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp geometry and split the address into line index and tag
    always_comb begin
        off_eff   = (offset_bits_reg > OFF_MAX) ? OFF_MAX : offset_bits_reg;
        ib_eff    = (index_bits_reg > IDX_MAX) ? IDX_MAX : index_bits_reg;
        tag_shift = {1'b0, off_eff} + {1'b0, ib_eff};
        shifted   = s_address >> off_eff;
        idx_mask  = {IDX_W{1'b1}} >> (IDX_MAX - ib_eff);
        new_req.line_index = shifted[IDX_W-1:0] & idx_mask;
        new_req.tag        = s_address >> tag_shift;
    end

    // two-entry queue toward the back end
    assign s_tready = !clear_busy && (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_req    = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= new_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, q_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[design/dmc_back.sv]
// back end: tag store lookup and update, counters and result register
module dmc_back import dmc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  dmc_req_t          q_req,
    output logic              q_pop,
    output logic              clear_busy,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_hit,
    output logic [IDX_W-1:0]  m_line_index,
    output logic [CNT_W-1:0]  m_access_count,
    output logic [CNT_W-1:0]  m_miss_count
);

    localparam logic [1:0] ST_CLEAR   = 2'd0;
    localparam logic [1:0] ST_IDLE    = 2'd1;
    localparam logic [1:0] ST_COMPARE = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] clr_addr_reg;
    dmc_req_t         pend_reg;
    logic [CNT_W-1:0] acc_reg;
    logic [CNT_W-1:0] miss_reg;
    logic             m_tvalid_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] line_index_reg;
    logic [CNT_W-1:0] acc_out_reg;
    logic [CNT_W-1:0] miss_out_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               slot_free;
    logic               finish;
    logic               hit;
    logic [CNT_W-1:0]   acc_next;
    logic [CNT_W-1:0]   miss_next;

    dmc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LINE_COUNT)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (q_pop),
        .raddr (q_req.line_index),
        .rdata (ram_rdata)
    );

    // handshake and lookup decisions
    assign slot_free  = !m_tvalid_reg || m_tready;
    assign clear_busy = (state_reg == ST_CLEAR);
    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign finish     = (state_reg == ST_COMPARE) && slot_free;
    assign hit        = ram_rdata[ENTRY_W-1] && (ram_rdata[TAG_W-1:0] == pend_reg.tag);
    assign acc_next   = (acc_reg == {CNT_W{1'b1}}) ? acc_reg : acc_reg + 1'b1;
    assign miss_next  = (hit || miss_reg == {CNT_W{1'b1}}) ? miss_reg : miss_reg + 1'b1;

    // tag store write: clearing pass or fill on miss
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = finish && !hit;
            ram_waddr = pend_reg.line_index;
            ram_wdata = {1'b1, pend_reg.tag};
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == {IDX_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            acc_reg      <= '0;
            miss_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (finish) begin
                acc_reg      <= acc_next;
                miss_reg     <= miss_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            pend_reg <= q_req;
        end
        if (finish) begin
            hit_reg        <= hit;
            line_index_reg <= pend_reg.line_index;
            acc_out_reg    <= acc_next;
            miss_out_reg   <= miss_next;
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign m_hit          = hit_reg;
    assign m_line_index   = line_index_reg;
    assign m_access_count = acc_out_reg;
    assign m_miss_count   = miss_out_reg;

endmodule
